>>> sv/segt_pkg.sv
// ----------------------------------------------------------------------------
// segt_pkg
// Shared types and constants for the range-minimum segment tree.
// ----------------------------------------------------------------------------
package segt_pkg;

  localparam int LEAVES_DEF = 1024;

  localparam logic signed [31:0] VAL_MAX       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] NEUTRAL_RESET = 32'sh7FFF_FFFF;

  localparam logic NEUTRAL_IDX = 1'b0;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_WALK
  } state_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [9:0]          position;
    logic signed [31:0]  new_value;
    logic [10:0]         range_low;
    logic [10:0]         range_high;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  min_result;
    logic                is_answer;
  } out_item_t;

  function automatic logic signed [31:0] min32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> sv/segment_tree_range_min.sv
// ----------------------------------------------------------------------------
// segment_tree_range_min
// Range-minimum segment tree over signed 32-bit leaves, held in one node RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the beat is taken at an edge where busy is
//   low. Each command gives exactly one result beat: out_valid is high for one
//   cycle with out_data. Queries set is_answer; clear, update and unused
//   commands return min_result 0.
//   Update: leaf write, then a sibling read and a parent write for each tree
//   level up to the root.
//   Query: bottom-up walk, at most one node read per cycle and at most one
//   read at each end of the range per level.
//   Clear: one node written per cycle, over all 2*PAD-1 nodes.
//   Out-of-range update and unused command: result beat in the cycle after accept.
//   Reset runs the same fill pass (all 2*PAD-1 nodes, busy high, no result beat)
//   with the reset neutral value; APB writes are taken meanwhile.
//   The receiver cannot stall; results are never held back.
//   The neutral_value register sits at APB byte address 0.
// ----------------------------------------------------------------------------
module segment_tree_range_min #(
  parameter int LEAVES = segt_pkg::LEAVES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  segt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output segt_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import segt_pkg::*;

  localparam int PAD   = 2 ** $clog2(LEAVES);
  localparam int NODES = 2 * PAD - 1;
  localparam int AW    = $clog2(NODES);
  localparam int IW    = AW + 1;
  localparam int QW    = (IW > 11) ? IW : 11;

  state_t state_r, state_nxt;

  logic signed [31:0] neutral_r;
  logic [AW-1:0]      fill_addr_r, fill_addr_nxt;
  logic signed [31:0] fill_val_r, fill_val_nxt;
  logic               fill_reply_r, fill_reply_nxt;
  logic [AW-1:0]      v_r, v_nxt;
  logic signed [31:0] cur_r, cur_nxt;
  logic [IW-1:0]      l_r, l_nxt;
  logic [IW-1:0]      r_r, r_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic               pend_r, pend_nxt;
  logic               full_r, full_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               accept;
  logic               cfg_wr;
  logic               fill_last;
  logic               pos_ok;
  logic [AW-1:0]      leaf_idx;
  logic [AW-1:0]      sib_idx;
  logic [AW-1:0]      par_idx;
  logic signed [31:0] par_val;
  logic [QW-1:0]      qlo_ext, qhi_ext;
  logic [IW-1:0]      lo_clip, hi_clip;
  logic               q_more;
  logic               q_re;
  logic [AW-1:0]      q_addr;
  logic [IW-1:0]      l_step, r_step;
  logic signed [31:0] acc_abs;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;
  logic               emit;
  out_item_t          res;

  segt_node_ram #(
    .DEPTH (NODES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // APB: single register, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == NEUTRAL_IDX);
  assign prdata = (paddr[2] == NEUTRAL_IDX) ? 32'(neutral_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r <= NEUTRAL_RESET;
    end else if (cfg_wr) begin
      neutral_r <= $signed(pwdata);
    end
  end

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // shared address math
  assign fill_last = (fill_addr_r == AW'(NODES - 1));
  assign pos_ok    = (QW'(in_data.position) < QW'(LEAVES));
  assign leaf_idx  = AW'(in_data.position) + AW'(PAD - 1);
  assign sib_idx   = v_r[0] ? (v_r + AW'(1)) : (v_r - AW'(1));
  assign par_idx   = (v_r - AW'(1)) >> 1;
  assign par_val   = min32(cur_r, mem_rdata);

  assign qlo_ext = QW'(in_data.range_low);
  assign qhi_ext = QW'(in_data.range_high);
  assign lo_clip = (qlo_ext >= QW'(PAD)) ? IW'(PAD) : IW'(qlo_ext);
  assign hi_clip = (qhi_ext >= QW'(PAD)) ? IW'(PAD) : IW'(qhi_ext);

  // at most one node read per cycle on the bottom-up walk (1-based heap indexes)
  assign q_more  = (l_r < r_r);
  assign acc_abs = pend_r ? min32(acc_r, mem_rdata) : acc_r;

  always_comb begin
    l_step = l_r;
    r_step = r_r;
    q_re   = 1'b0;
    q_addr = '0;
    if (l_r[0]) begin
      q_re   = 1'b1;
      q_addr = AW'(l_r - IW'(1));
      l_step = l_r + IW'(1);
    end else if (r_r[0]) begin
      q_re   = 1'b1;
      q_addr = AW'(r_r - IW'(2));
      r_step = r_r - IW'(1);
    end
    if (!l_step[0] && !r_step[0]) begin
      l_step = l_step >> 1;
      r_step = r_step >> 1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_FILL: begin
        if (fill_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_CLEAR:  state_nxt = ST_FILL;
            ACT_UPDATE: state_nxt = pos_ok ? ST_UPD_RD : ST_IDLE;
            ACT_QUERY:  state_nxt = ST_QRY_WALK;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_UPD_RD: state_nxt = ST_UPD_WR;
      ST_UPD_WR: state_nxt = (par_idx == '0) ? ST_IDLE : ST_UPD_RD;
      ST_QRY_WALK: begin
        if (!q_more) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: RAM controls and result beat
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    emit      = 1'b0;
    res       = '0;
    case (state_r)
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_addr_r;
        mem_wdata = fill_val_r;
        emit      = fill_last && fill_reply_r;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_CLEAR: ;
            ACT_UPDATE: begin
              mem_we    = pos_ok;
              mem_waddr = leaf_idx;
              mem_wdata = in_data.new_value;
              emit      = !pos_ok;
            end
            ACT_QUERY: ;
            default: emit = 1'b1;
          endcase
        end
      end
      ST_UPD_RD: begin
        mem_re    = 1'b1;
        mem_raddr = sib_idx;
      end
      ST_UPD_WR: begin
        mem_we    = 1'b1;
        mem_waddr = par_idx;
        mem_wdata = par_val;
        emit      = (par_idx == '0);
      end
      ST_QRY_WALK: begin
        mem_re    = q_more && q_re;
        mem_raddr = q_addr;
        if (!q_more) begin
          emit           = 1'b1;
          res.is_answer  = 1'b1;
          // only a whole-tree cover skips the neutral term
          res.min_result = full_r ? acc_abs : min32(neutral_r, acc_abs);
        end
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    fill_addr_nxt  = fill_addr_r;
    fill_val_nxt   = fill_val_r;
    fill_reply_nxt = fill_reply_r;
    v_nxt          = v_r;
    cur_nxt        = cur_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    acc_nxt        = acc_r;
    pend_nxt       = 1'b0;
    full_nxt       = full_r;
    case (state_r)
      ST_FILL: begin
        fill_addr_nxt = fill_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_CLEAR: begin
              fill_addr_nxt  = '0;
              fill_val_nxt   = neutral_r;
              fill_reply_nxt = 1'b1;
            end
            ACT_UPDATE: begin
              v_nxt   = leaf_idx;
              cur_nxt = in_data.new_value;
            end
            ACT_QUERY: begin
              l_nxt    = lo_clip + IW'(PAD);
              r_nxt    = hi_clip + IW'(PAD);
              acc_nxt  = VAL_MAX;
              full_nxt = (in_data.range_low == '0) && (qhi_ext >= QW'(PAD));
            end
            default: ;
          endcase
        end
      end
      ST_UPD_WR: begin
        v_nxt   = par_idx;
        cur_nxt = par_val;
      end
      ST_QRY_WALK: begin
        acc_nxt = acc_abs;
        if (q_more) begin
          l_nxt    = l_step;
          r_nxt    = r_step;
          pend_nxt = q_re;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      fill_addr_r  <= '0;
      fill_val_r   <= NEUTRAL_RESET;
      fill_reply_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_addr_r  <= fill_addr_nxt;
      fill_val_r   <= fill_val_nxt;
      fill_reply_r <= fill_reply_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= emit;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    cur_r  <= cur_nxt;
    l_r    <= l_nxt;
    r_r    <= r_nxt;
    acc_r  <= acc_nxt;
    full_r <= full_nxt;
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_fill_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("fill pass not running after reset");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRY_WALK) |-> !mem_we)
    else $error("node write during query walk");

  a_upd_below_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD_RD || state_r == ST_UPD_WR) |-> (v_r != '0))
    else $error("update walk went past the root");

  a_beat_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result beat while a command is still running");

  a_non_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.is_answer) |-> (out_data.min_result == 32'sd0))
    else $error("non-query result carries a value");

endmodule

>>> sv/segt_node_ram.sv
// ----------------------------------------------------------------------------
// segt_node_ram
// Node storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module segt_node_ram #(
  parameter int DEPTH = 2047,
  parameter int AW    = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [31:0]       wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [31:0]       rd_data
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
